@@ design/sdaf_pkg.sv @@
// Shared types, constants and helper functions of the signed decimal ASCII formatter.
// Used by the front, queue, back and top-level modules; depends on nothing else.
`timescale 1ns / 1ps

package sdaf_pkg;

	localparam int ValueW = 32;
	localparam int MagW   = 20;
	localparam int CharW  = 7;
	localparam int DataW  = 8;
	localparam int QDepth = 2;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	localparam logic [CharW-1:0] CharMinus = 7'h2D;
	localparam logic [CharW-1:0] CharPoint = 7'h2E;
	localparam logic [CharW-1:0] CharZero  = 7'd48;
	localparam logic [CharW-1:0] CharNine  = 7'd57;

	localparam logic [MagW-1:0] IntLimit = 20'd99999;
	localparam logic [MagW-1:0] HunLimit = 20'd999999;

	typedef enum logic {
		ModeInt = 1'b0,
		ModeHun = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		KindMinus,
		KindPoint,
		KindDigit
	} kind_t;

	// One classified value waiting for the character sequencer.
	typedef struct packed {
		mode_t           mode;
		logic            neg;
		logic [MagW-1:0] mag;
	} item_t;

	// Weight of a digit place, from 100000 down to 1.
	function automatic logic [MagW-1:0] place_weight(input logic [2:0] idx);
		logic [MagW-1:0] w;
		unique case (idx)
			3'd0:    w = 20'd100000;
			3'd1:    w = 20'd10000;
			3'd2:    w = 20'd1000;
			3'd3:    w = 20'd100;
			3'd4:    w = 20'd10;
			3'd5:    w = 20'd1;
			default: w = 20'd0;
		endcase
		return w;
	endfunction

endpackage

@@ design/sdaf_front.sv @@
// Input stage of the formatter: registers one value and classifies it (sign, saturated magnitude).
// Depends on sdaf_pkg; feeds sdaf_queue.
`timescale 1ns / 1ps

module sdaf_front
	import sdaf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ValueW-1:0] s_tdata,   // [31:0] value
	input  logic              s_tuser,   // [0] mode
	input  logic              q_full,
	output logic              q_wr,
	output item_t             q_item
);

	logic              valid_s1;
	mode_t             mode_s1;
	logic [ValueW-1:0] value_s1;

	logic              accept;
	logic              neg;
	logic [ValueW-1:0] mag_full;
	logic [ValueW-1:0] lim_pos;
	logic [ValueW-1:0] lim_neg;
	logic [MagW-1:0]   limit;
	logic              sat;

	assign s_tready = !valid_s1 || !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_wr     = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && q_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1  <= mode_t'(s_tuser);
			value_s1 <= s_tdata;
		end
	end

	// The negation is taken as unsigned, so the most negative value gives its true magnitude.
	// Saturation is decided on the signed value, in parallel with the negation.
	always_comb begin
		limit    = (mode_s1 == ModeHun) ? HunLimit : IntLimit;
		lim_pos  = {{(ValueW - MagW){1'b0}}, limit};
		lim_neg  = '0 - lim_pos;
		neg      = value_s1[ValueW-1];
		mag_full = neg ? ('0 - value_s1) : value_s1;
		sat      = neg ? ($signed(value_s1) < $signed(lim_neg))
		               : ($signed(value_s1) > $signed(lim_pos));
		q_item.mode = mode_s1;
		q_item.neg  = neg;
		q_item.mag  = sat ? limit : mag_full[MagW-1:0];
	end

endmodule

@@ design/sdaf_queue.sv @@
// Short queue of classified values between the front and the character sequencer.
// Depends on sdaf_pkg.
`timescale 1ns / 1ps

module sdaf_queue
	import sdaf_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd,
	output logic  rd_valid,
	output item_t rd_item
);

	item_t            entry_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign full     = (count_q == QCntW'(QDepth));
	assign rd_valid = (count_q != '0);
	assign rd_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

@@ design/sdaf_back.sv @@
// Character sequencer: turns one queued value into ASCII text, one character a cycle when
// not stalled, and holds each character in the output register. Depends on sdaf_pkg.
`timescale 1ns / 1ps

module sdaf_back
	import sdaf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  item_t            q_item,
	output logic             q_rd,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [DataW-1:0] m_tdata,   // [6:0] character, [7] zero
	output logic             m_tlast    // [0] last
);

	logic            busy_q;
	mode_t           mode_q;
	logic            neg_q;
	logic [2:0]      slot_q;
	logic [MagW-1:0] rem_q;
	logic            out_valid_q;
	logic [CharW-1:0] out_char_q;
	logic            out_last_q;

	logic             adv;
	logic             is_last;
	logic [2:0]       last_slot;
	logic [2:0]       j;
	logic [2:0]       idx;
	kind_t            kind;
	logic [MagW-1:0]  weight;
	logic [MagW-1:0]  thr [10];
	logic [3:0]       digit;
	logic [MagW-1:0]  sub;
	logic [CharW-1:0] ch;

	assign adv  = busy_q && (!out_valid_q || m_tready);
	assign q_rd = q_valid && (!busy_q || (adv && is_last));

	// Which character this slot carries, and which digit place it prints.
	always_comb begin
		last_slot = ((mode_q == ModeHun) ? 3'd6 : 3'd4) + {2'b00, neg_q};
		is_last   = (slot_q == last_slot);
		j         = slot_q - {2'b00, neg_q};
		idx       = '0;
		kind      = KindDigit;
		if (neg_q && slot_q == 3'd0) begin
			kind = KindMinus;
		end else if (mode_q == ModeHun) begin
			if (j == 3'd4) begin
				kind = KindPoint;
			end
			idx = (j < 3'd4) ? j : j - 3'd1;
		end else begin
			idx = j + 3'd1;
		end
	end

	// The digit is the largest multiple of the place weight that still fits in the remainder.
	always_comb begin
		weight = place_weight(idx);
		digit  = '0;
		for (int k = 0; k < 10; k++) begin
			thr[k] = MagW'(weight * MagW'(k));
		end
		for (int k = 1; k < 10; k++) begin
			if (rem_q >= thr[k]) begin
				digit = 4'(k);
			end
		end
		sub = thr[digit];
		unique case (kind)
			KindMinus: ch = CharMinus;
			KindPoint: ch = CharPoint;
			KindDigit: ch = CharZero + {3'b000, digit};
			default:   ch = CharZero;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_rd) begin
				busy_q <= 1'b1;
			end else if (adv && is_last) begin
				busy_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			mode_q <= q_item.mode;
			neg_q  <= q_item.neg;
			rem_q  <= q_item.mag;
			slot_q <= '0;
		end else if (adv) begin
			slot_q <= slot_q + 3'd1;
			if (kind == KindDigit) begin
				rem_q <= rem_q - sub;
			end
		end
		if (adv) begin
			out_char_q <= ch;
			out_last_q <= is_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_char_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (slot_q <= last_slot))
		else $error("character slot runs past the end of the text");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q <= HunLimit))
		else $error("remainder exceeds the saturated magnitude");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_char_q == CharMinus || out_char_q == CharPoint ||
			(out_char_q >= CharZero && out_char_q <= CharNine)))
		else $error("output character outside the decimal text set");

	a_pop_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(q_rd && busy_q) |-> (adv && is_last))
		else $error("new value loaded before the current text ended");
`endif

endmodule

@@ design/signed_decimal_ascii_formatter_top.sv @@
// Top level of the signed decimal ASCII formatter: front classifier, queue and character sequencer.
// Depends on sdaf_pkg, sdaf_front, sdaf_queue and sdaf_back.
//
// Channel   Direction  Data                       Side band
// s_*       input      tdata[31:0] value          tuser[0] mode (0 integer, 1 hundredths)
// m_*       output     tdata[6:0] character       tlast: final character of one value
//
// Each value yields 5 to 8 characters (integer 5, hundredths 7, one more for a minus sign),
// sent one per cycle from the single output register while the sink does not stall; the sequencer
// sets the sustained rate. Values enter back to back until the two-entry queue and the input
// register are full. Each value passes a queue entry and the sequencer registers on its way out.
// Reset clears only control state. Either side may stall at any time without loss.
`timescale 1ns / 1ps

module signed_decimal_ascii_formatter_top
	import sdaf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [ValueW-1:0] s_tdata,   // [31:0] value
	input  logic              s_tuser,   // [0] mode
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DataW-1:0]  m_tdata,   // [6:0] character, [7] zero
	output logic              m_tlast    // [0] last
);

	logic  q_full;
	logic  q_wr;
	item_t q_wr_item;
	logic  q_rd;
	logic  q_valid;
	item_t q_rd_item;

	sdaf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_wr     (q_wr),
		.q_item   (q_wr_item)
	);

	sdaf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wr_item  (q_wr_item),
		.full     (q_full),
		.rd       (q_rd),
		.rd_valid (q_valid),
		.rd_item  (q_rd_item)
	);

	sdaf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_rd_item),
		.q_rd     (q_rd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
